FILE: design/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types and constants for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int VALUE_W    = 64;
  localparam int BCD_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int SR_W       = BCD_DIGITS * DIGIT_W;  // 80-bit digit shift register
  localparam int CNT_W      = 7;

  localparam logic [CNT_W-1:0] MAX_DIGITS = 7'd64;
  localparam logic [CNT_W-1:0] DEC_SLOTS  = 7'd20;
  localparam logic [CNT_W-1:0] BIN_SLOTS  = 7'd64;
  localparam logic [CNT_W-1:0] OCT_SLOTS  = 7'd22;
  localparam logic [CNT_W-1:0] HEX_SLOTS  = 7'd16;

  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CASE_OFFSET  = 7'h20;  // 'a' - 'A'
  localparam logic [6:0] CHAR_MINUS   = 7'h2d;
  localparam logic [6:0] CHAR_NONE    = 7'h00;

  typedef enum logic [2:0] {
    RADIX_DEC    = 3'd0,
    RADIX_BIN    = 3'd1,
    RADIX_OCT    = 3'd2,
    RADIX_HEX_LO = 3'd3,
    RADIX_HEX_UP = 3'd4
  } radix_t;

  typedef enum logic [1:0] {
    DW_1 = 2'd0,
    DW_3 = 2'd1,
    DW_4 = 2'd2
  } dwidth_t;

endpackage

FILE: design/ita_dabble.sv
// ----------------------------------------------------------------------------
// ita_dabble
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// ----------------------------------------------------------------------------
module ita_dabble
  import ita_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] bin,
  output logic               done,
  output logic [SR_W-1:0]    bcd
);

  logic [VALUE_W-1:0] bin_sr;
  logic [SR_W-1:0]    bcd_adj;
  logic [5:0]         cnt;
  logic               run;

  // correct every digit that would overflow on the next doubling
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_sr <= bin;
      bcd    <= '0;
    end else if (run) begin
      bcd    <= {bcd_adj[SR_W-2:0], bin_sr[VALUE_W-1]};
      bin_sr <= {bin_sr[VALUE_W-2:0], 1'b0};
    end
  end

endmodule

FILE: design/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a 64-bit value to ASCII text in decimal, binary, octal or hex,
// most significant digit first, one character beat per cycle.
// ----------------------------------------------------------------------------
// Flow: decimal values first pass the shift-and-add-three converter, while
//   power-of-two radices scan now; each dropped leading zero delays the first beat.
// Items: one at a time, next accept in the cycle that shows the final beat.
// Reset clears the control state only; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix
  import ita_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  input  logic               is_signed,
  input  logic [2:0]         radix_select,
  input  logic [6:0]         max_chars,
  output logic               busy,
  output logic               strobe,
  output logic [6:0]         character,
  output logic               char_valid,
  output logic [6:0]         full_length,
  output logic               last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t             state;
  dwidth_t            dw;
  logic               upper;
  logic               minus;
  logic [6:0]         limit;
  logic [CNT_W-1:0]   slots;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   rem;
  logic [SR_W-1:0]    dig_sr;
  logic [SR_W-1:0]    dig_sr_shift;
  logic [DIGIT_W-1:0] top_digit;
  logic [6:0]         top_char;
  logic [CNT_W-1:0]   total_next;
  logic [CNT_W-1:0]   emit_next;
  logic               neg_in;
  logic [VALUE_W-1:0] mag_in;
  logic               dab_start;
  logic               dab_done;
  logic [SR_W-1:0]    dab_bcd;
  logic               accept;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign neg_in    = is_signed && value[VALUE_W-1] && (max_chars != 7'd0);
  assign mag_in    = neg_in ? (~value + 64'd1) : value;
  assign dab_start = accept && (radix_select != RADIX_BIN) && (radix_select != RADIX_OCT)
                     && (radix_select != RADIX_HEX_LO) && (radix_select != RADIX_HEX_UP);

  ita_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (dab_start),
    .bin   (mag_in),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  always_comb begin
    case (dw)
      DW_1: begin
        top_digit    = {3'b000, dig_sr[SR_W-1]};
        dig_sr_shift = {dig_sr[SR_W-2:0], 1'b0};
      end
      DW_3: begin
        top_digit    = {1'b0, dig_sr[SR_W-1 -: 3]};
        dig_sr_shift = {dig_sr[SR_W-4:0], 3'b000};
      end
      default: begin
        top_digit    = dig_sr[SR_W-1 -: DIGIT_W];
        dig_sr_shift = {dig_sr[SR_W-DIGIT_W-1:0], 4'b0000};
      end
    endcase
  end

  always_comb begin
    if (top_digit < 4'd10) begin
      top_char = CHAR_ZERO + {3'b000, top_digit};
    end else if (upper) begin
      top_char = (CHAR_LOWER_A - CASE_OFFSET) + {3'b000, top_digit - 4'd10};
    end else begin
      top_char = CHAR_LOWER_A + {3'b000, top_digit - 4'd10};
    end
  end

  always_comb begin
    total_next = slots + {{(CNT_W-1){1'b0}}, minus};
    emit_next  = total_next;
    if (emit_next > limit) emit_next = limit;
    if (emit_next > MAX_DIGITS) emit_next = MAX_DIGITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= dab_start ? S_CONV : S_SKIP;
          end
        end
        S_CONV: begin
          if (dab_done) state <= S_SKIP;
        end
        S_SKIP: begin
          if (!(slots > 7'd1 && top_digit == '0)) begin
            if (limit == 7'd0) begin
              strobe <= 1'b1;
              state  <= S_IDLE;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          strobe <= 1'b1;
          if (rem == 7'd1) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          minus <= neg_in;
          limit <= max_chars;
          upper <= (radix_select == RADIX_HEX_UP);
          case (radix_select)
            RADIX_BIN: begin
              dw     <= DW_1;
              slots  <= BIN_SLOTS;
              dig_sr <= {mag_in, 16'h0000};
            end
            RADIX_OCT: begin
              dw     <= DW_3;
              slots  <= OCT_SLOTS;
              dig_sr <= {2'b00, mag_in, 14'h0000};
            end
            RADIX_HEX_LO, RADIX_HEX_UP: begin
              dw     <= DW_4;
              slots  <= HEX_SLOTS;
              dig_sr <= {mag_in, 16'h0000};
            end
            default: begin
              dw    <= DW_4;
              slots <= DEC_SLOTS;
            end
          endcase
        end
      end
      S_CONV: begin
        if (dab_done) dig_sr <= dab_bcd;
      end
      S_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (slots > 7'd1 && top_digit == '0) begin
          dig_sr <= dig_sr_shift;
          slots  <= slots - 7'd1;
        end else begin
          total <= total_next;
          rem   <= emit_next;
          if (limit == 7'd0) begin
            character   <= CHAR_NONE;
            char_valid  <= 1'b0;
            full_length <= total_next;
            last        <= 1'b1;
          end
        end
      end
      S_EMIT: begin
        rem         <= rem - 7'd1;
        char_valid  <= 1'b1;
        full_length <= total;
        last        <= (rem == 7'd1);
        if (minus) begin
          character <= CHAR_MINUS;
          minus     <= 1'b0;
        end else begin
          character <= top_char;
          dig_sr    <= dig_sr_shift;
        end
      end
      default: begin
      end
    endcase
  end

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result beat right after a final beat");

  a_invalid_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !char_valid |-> last)
    else $error("empty result beat not marked final");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (full_length != 7'd0) && (full_length <= 7'd65))
    else $error("full length out of range");

  a_beats_while_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final beat with converter idle");

endmodule
